FILE: sv/acc_pkg.sv
package acc_pkg;

   localparam int ADDR_W      = 24;
   localparam int LEN_W       = 4;
   localparam int CHAR_W      = 8;
   localparam int CAT_W       = 2;
   localparam int KEY_CHARS   = 5;
   localparam int NUM_RANGES  = 5;
   localparam int NUM_PREFIXES = 20;

   localparam logic [CAT_W-1:0] CAT_UNKNOWN = 2'd0;
   localparam logic [CAT_W-1:0] CAT_MIL     = 2'd1;
   localparam logic [CAT_W-1:0] CAT_GA      = 2'd2;
   localparam logic [CAT_W-1:0] CAT_COM     = 2'd3;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [KEY_CHARS-1:0][CHAR_W-1:0] key_chars_type;
   typedef logic [KEY_CHARS*CHAR_W-1:0] prefix_type;

   typedef struct packed {
      key_chars_type         chars;
      logic [NUM_RANGES-1:0] range_hit;
   } norm_type;

   typedef struct packed {
      logic mil;
      logic ga;
      logic com;
   } flags_type;

   localparam logic [ADDR_W-1:0] RANGE_LO [NUM_RANGES] = '{
      24'hADF7C8, 24'h43C000, 24'h3F8000, 24'h3B7000, 24'hC87F00
   };
   localparam logic [ADDR_W-1:0] RANGE_HI [NUM_RANGES] = '{
      24'hAFFFFF, 24'h43FFFF, 24'h3FFFFF, 24'h3B7FFF, 24'hC87FFF
   };

   // upper-case ASCII, first character in the top byte, zero padded
   localparam prefix_type PREFIX_TABLE [NUM_PREFIXES] = '{
      40'h5243480000, 40'h53414D0000, 40'h5041540000, 40'h534841444F,
      40'h4B4E494645, 40'h4752494D00, 40'h5350415200, 40'h434E560000,
      40'h5656000000, 40'h4E41565900, 40'h4D43000000, 40'h41524D5900,
      40'h4347000000, 40'h5252520000, 40'h4E41544F00, 40'h4D41474D41,
      40'h4346430000, 40'h4855534B59, 40'h434F54414D, 40'h4741460000
   };

   function automatic logic is_letter(input char_type c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input char_type c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic char_type fold_up(input char_type c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
   endfunction

endpackage

FILE: sv/acc_norm.sv
module acc_norm (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [acc_pkg::ADDR_W-1:0]     address,
   input  logic [acc_pkg::LEN_W-1:0]      callsign_len,
   input  acc_pkg::key_chars_type         chars,
   output logic                           out_valid,
   input  logic                           out_ready,
   output acc_pkg::norm_type              out_data
);
   import acc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   norm_type data_ff;
   norm_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      logic live;
      live = 1'b1;
      data_in = data_ff;
      for (int k = 0; k < KEY_CHARS; k++) begin
         if (callsign_len <= LEN_W'(k) || chars[k] == '0) begin
            live = 1'b0;
         end
         data_in.chars[k] = live ? chars[k] : '0;
      end
      for (int r = 0; r < NUM_RANGES; r++) begin
         data_in.range_hit[r] = address >= RANGE_LO[r] && address <= RANGE_HI[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: sv/acc_match.sv
module acc_match (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  acc_pkg::norm_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output acc_pkg::flags_type out_data
);
   import acc_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   flags_type data_ff;
   flags_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      key_chars_type         c;
      key_chars_type         up;
      logic [NUM_PREFIXES-1:0] pfx_hit;
      char_type              want;
      logic                  two;
      c = in_data.chars;
      for (int k = 0; k < KEY_CHARS; k++) begin
         up[k] = fold_up(c[k]);
      end
      for (int p = 0; p < NUM_PREFIXES; p++) begin
         pfx_hit[p] = 1'b1;
         for (int k = 0; k < KEY_CHARS; k++) begin
            want = PREFIX_TABLE[p][(KEY_CHARS-1-k)*CHAR_W +: CHAR_W];
            if (want != '0 && up[k] != want) begin
               pfx_hit[p] = 1'b0;
            end
         end
      end
      two = is_letter(c[1]) && is_letter(c[2]);
      data_in.mil = (|in_data.range_hit) || (|pfx_hit);
      data_in.ga  = (c[0] == "N" && is_digit(c[1]))
                 || ((c[0] == "G" || c[0] == "D" || c[0] == "F") && two)
                 || (c[0] == "E" && c[1] == "I" && is_letter(c[2]))
                 || (c[0] == "C" && two && c[1] != "F");
      data_in.com = is_letter(c[0]) && is_letter(c[1]) && is_letter(c[2])
                 && is_digit(c[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: sv/acc_decide.sv
module acc_decide (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  acc_pkg::flags_type        in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [acc_pkg::CAT_W-1:0] category
);
   import acc_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   logic [CAT_W-1:0] cat_ff;
   logic [CAT_W-1:0] cat_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      if (in_data.mil) begin
         cat_in = CAT_MIL;
      end else if (in_data.ga) begin
         cat_in = CAT_GA;
      end else if (in_data.com) begin
         cat_in = CAT_COM;
      end else begin
         cat_in = CAT_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         cat_ff <= cat_in;
      end
   end

   assign out_valid = valid_ff;
   assign category  = cat_ff;

endmodule

FILE: sv/aircraft_callsign_classifier.sv
// Aircraft record classifier.
// Request channel (req_valid/req_ready): one record per transaction, a 24-bit
// transponder address, a callsign length and eight callsign bytes. The
// callsign ends at the length or at the first zero byte; only its first five
// characters decide the category.
// Response channel (rsp_valid/rsp_ready): one 2-bit category per record, in
// request order: unknown, military, general aviation, commercial.
// Each request passes through three register stages in order: callsign
// masking and address range compares, prefix and pattern matching,
// category priority select.
// Throughput is one record per cycle while rsp_ready is high. Each stage
// takes a new transaction whenever it is empty or the stage after it
// advances, so req_ready drops only when all three stages hold a
// transaction and rsp_ready is low. A stall on rsp_ready holds the last
// stage and each full stage whose next stage is full, with its payload;
// nothing is lost or repeated. Synchronous reset empties all stages; the
// block takes a request in the first cycle after reset.
module aircraft_callsign_classifier (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [acc_pkg::ADDR_W-1:0] req_address,
   input  logic [acc_pkg::LEN_W-1:0] req_callsign_len,
   input  logic [acc_pkg::CHAR_W-1:0] req_char_0,
   input  logic [acc_pkg::CHAR_W-1:0] req_char_1,
   input  logic [acc_pkg::CHAR_W-1:0] req_char_2,
   input  logic [acc_pkg::CHAR_W-1:0] req_char_3,
   input  logic [acc_pkg::CHAR_W-1:0] req_char_4,
   input  logic [acc_pkg::CHAR_W-1:0] req_char_5,
   input  logic [acc_pkg::CHAR_W-1:0] req_char_6,
   input  logic [acc_pkg::CHAR_W-1:0] req_char_7,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [acc_pkg::CAT_W-1:0] rsp_category
);
   import acc_pkg::*;

   key_chars_type key_chars;
   norm_type      norm_data;
   flags_type     flags_data;
   logic          norm_valid;
   logic          norm_ready;
   logic          match_valid;
   logic          match_ready;

   // characters past the fifth never change the category
   assign key_chars = {req_char_4, req_char_3, req_char_2, req_char_1, req_char_0};

   acc_norm u_norm (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .address      (req_address),
      .callsign_len (req_callsign_len),
      .chars        (key_chars),
      .out_valid    (norm_valid),
      .out_ready    (norm_ready),
      .out_data     (norm_data)
   );

   acc_match u_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_ready  (norm_ready),
      .in_data   (norm_data),
      .out_valid (match_valid),
      .out_ready (match_ready),
      .out_data  (flags_data)
   );

   acc_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (match_valid),
      .in_ready  (match_ready),
      .in_data   (flags_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .category  (rsp_category)
   );

endmodule
